// ===== rtl/utf16_to_utf8_transcoder_macros.svh =====
// Assertion macros shared by the transcoder RTL.
`ifndef UTF16_TO_UTF8_TRANSCODER_MACROS_SVH
`define UTF16_TO_UTF8_TRANSCODER_MACROS_SVH

// Condition must hold on every clock edge outside reset.
`define UTT_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("transcoder check failed");

// Consequent must hold in the same cycle as the antecedent.
`define UTT_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("transcoder check failed");

`endif

// ===== rtl/utt_pkg.sv =====
// Types and constants for the UTF-16 to UTF-8 transcoder.
package utt_pkg;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        last_unit;
  } unit_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last_of_run;
    logic       end_of_string;
    logic [1:0] error_code;
  } result_t;

  // One decoded transaction for the byte emitter: bytes[0] goes first.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
    logic            byte_valid;
    logic            end_of_string;
    logic [1:0]      error_code;
  } job_t;

  localparam logic [1:0] ERR_OK         = 2'd0;
  localparam logic [1:0] ERR_UNMATCHED  = 2'd1;
  localparam logic [1:0] ERR_BAD_PAIR   = 2'd2;
  localparam logic [1:0] ERR_EMBED_NULL = 2'd3;

  localparam logic [15:0] HIGH_FIRST = 16'hD800;
  localparam logic [15:0] HIGH_LAST  = 16'hDBFF;
  localparam logic [15:0] LOW_FIRST  = 16'hDC00;
  localparam logic [15:0] LOW_LAST   = 16'hDFFF;
  localparam logic [15:0] ONE_MAX    = 16'h007F;
  localparam logic [15:0] TWO_MAX    = 16'h07FF;

  localparam logic [10:0] PLANE_OFFSET = 11'd64;  // 0x10000 >> 10

  localparam logic [7:0] LEAD2     = 8'hC0;
  localparam logic [7:0] LEAD3     = 8'hE0;
  localparam logic [7:0] LEAD4     = 8'hF0;
  localparam logic [7:0] CONT_MARK = 8'h80;

  localparam logic [1:0] IDX_ONE   = 2'd0;
  localparam logic [1:0] IDX_TWO   = 2'd1;
  localparam logic [1:0] IDX_THREE = 2'd2;
  localparam logic [1:0] IDX_FOUR  = 2'd3;

  localparam int QUEUE_DEPTH = 2;

endpackage

// ===== rtl/utt_front.sv =====
// Front end: accepts code units, pairs surrogates and builds byte jobs.
module utt_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           unit_valid,
  output logic           unit_stall,
  input  utt_pkg::unit_t unit_data,
  input  logic           q_full,
  output logic           q_push,
  output utt_pkg::job_t  q_data
);

  logic [9:0]  pending_high;
  logic [9:0]  pending_high_next;
  logic        have_pending;
  logic        have_pending_next;
  logic        accept;
  logic        emit;
  logic        is_high;
  logic        is_low;
  logic [15:0] cu;
  logic [10:0] plane;
  logic [20:0] cp;

  assign unit_stall = q_full;
  assign accept     = unit_valid && !q_full;
  assign q_push     = accept && emit;
  assign cu         = unit_data.code_unit;
  assign plane      = {1'b0, pending_high} + utt_pkg::PLANE_OFFSET;
  assign cp         = {plane[10:0], cu[9:0]};

  always_comb begin
    is_high = cu inside {[utt_pkg::HIGH_FIRST:utt_pkg::HIGH_LAST]};
    is_low  = cu inside {[utt_pkg::LOW_FIRST:utt_pkg::LOW_LAST]};
  end

  always_comb begin
    emit                 = 1'b1;
    pending_high_next    = pending_high;
    have_pending_next    = have_pending;
    q_data.bytes         = '0;
    q_data.last_idx      = utt_pkg::IDX_ONE;
    q_data.byte_valid    = 1'b1;
    q_data.end_of_string = unit_data.last_unit;
    q_data.error_code    = utt_pkg::ERR_OK;
    if (have_pending) begin
      pending_high_next = '0;
      have_pending_next = 1'b0;
      if (!is_low) begin
        q_data.byte_valid    = 1'b0;
        q_data.end_of_string = 1'b1;
        q_data.error_code    = utt_pkg::ERR_BAD_PAIR;
      end else begin
        q_data.bytes[0] = utt_pkg::LEAD4 | {5'd0, cp[20:18]};
        q_data.bytes[1] = utt_pkg::CONT_MARK | {2'd0, cp[17:12]};
        q_data.bytes[2] = utt_pkg::CONT_MARK | {2'd0, cp[11:6]};
        q_data.bytes[3] = utt_pkg::CONT_MARK | {2'd0, cp[5:0]};
        q_data.last_idx = utt_pkg::IDX_FOUR;
      end
    end else if (is_high) begin
      if (unit_data.last_unit) begin
        q_data.byte_valid    = 1'b0;
        q_data.end_of_string = 1'b1;
        q_data.error_code    = utt_pkg::ERR_UNMATCHED;
      end else begin
        emit              = 1'b0;
        pending_high_next = cu[9:0];
        have_pending_next = 1'b1;
      end
    end else if (is_low) begin
      q_data.byte_valid    = 1'b0;
      q_data.end_of_string = 1'b1;
      q_data.error_code    = utt_pkg::ERR_UNMATCHED;
    end else if (cu == '0) begin
      q_data.byte_valid    = 1'b0;
      q_data.end_of_string = 1'b1;
      if (!unit_data.last_unit) begin
        q_data.error_code = utt_pkg::ERR_EMBED_NULL;
      end
    end else if (cu <= utt_pkg::ONE_MAX) begin
      q_data.bytes[0] = cu[7:0];
    end else if (cu <= utt_pkg::TWO_MAX) begin
      q_data.bytes[0] = utt_pkg::LEAD2 | {3'd0, cu[10:6]};
      q_data.bytes[1] = utt_pkg::CONT_MARK | {2'd0, cu[5:0]};
      q_data.last_idx = utt_pkg::IDX_TWO;
    end else begin
      q_data.bytes[0] = utt_pkg::LEAD3 | {4'd0, cu[15:12]};
      q_data.bytes[1] = utt_pkg::CONT_MARK | {2'd0, cu[11:6]};
      q_data.bytes[2] = utt_pkg::CONT_MARK | {2'd0, cu[5:0]};
      q_data.last_idx = utt_pkg::IDX_THREE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_high <= '0;
      have_pending <= 1'b0;
    end else if (accept) begin
      pending_high <= pending_high_next;
      have_pending <= have_pending_next;
    end
  end

endmodule

// ===== rtl/utt_queue.sv =====
// Short job queue between the front end and the byte emitter.
module utt_queue #(
  parameter int Depth = utt_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  utt_pkg::job_t push_data,
  input  logic          pop,
  output utt_pkg::job_t head,
  output logic          not_empty,
  output logic          full
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  utt_pkg::job_t         entries [Depth];
  logic [PtrW-1:0]       wr_ptr;
  logic [PtrW-1:0]       rd_ptr;
  logic [CntW-1:0]       count;

  assign head      = entries[rd_ptr];
  assign not_empty = (count != '0);
  assign full      = (count == CntFull);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrLast) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrLast) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/utt_back.sv =====
// Back end: walks a job one byte per cycle into the output register while res_stall is low.
module utt_back (
  input  logic             clk,
  input  logic             rst,
  input  utt_pkg::job_t    head,
  input  logic             not_empty,
  output logic             pop,
  output logic             res_valid,
  input  logic             res_stall,
  output utt_pkg::result_t res_data
);

  logic [1:0] idx;
  logic       load;
  logic       final_byte;

  assign load       = !res_valid || !res_stall;
  assign final_byte = (idx == head.last_idx);
  assign pop        = load && not_empty && final_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      res_valid <= not_empty;
      if (not_empty) begin
        idx <= final_byte ? '0 : idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && not_empty) begin
      res_data.out_byte      <= head.bytes[idx];
      res_data.byte_valid    <= head.byte_valid;
      res_data.last_of_run   <= final_byte;
      res_data.end_of_string <= final_byte && head.end_of_string;
      res_data.error_code    <= head.error_code;
    end
  end

endmodule

// ===== rtl/utf16_to_utf8_transcoder.sv =====
// Top level of the UTF-16 to UTF-8 transcoder.
//
//   port group   dir  payload     meaning
//   unit_*       in   unit_t      one UTF-16 code unit, last-unit flag
//   res_*        out  result_t    one UTF-8 byte or a status transaction
//
// A code unit is taken in every cycle while the job queue has room.
// The emitter sends one result per cycle while res_stall is low: a basic-plane
// unit gives one to three results, a surrogate pair four over its two units,
// an error or end marker one. The emitter's byte walk sets the sustained rate.
// Synchronous reset clears the held surrogate, queue pointers and output valid.
// res_stall holds the output register; unit_stall rises only when the queue is full.
`include "utf16_to_utf8_transcoder_macros.svh"

module utf16_to_utf8_transcoder #(
  parameter int QueueDepth = utt_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             unit_valid,
  output logic             unit_stall,
  input  utt_pkg::unit_t   unit_data,
  output logic             res_valid,
  input  logic             res_stall,
  output utt_pkg::result_t res_data
);

  utt_pkg::job_t push_job;
  utt_pkg::job_t head_job;
  logic          q_push;
  logic          q_pop;
  logic          q_full;
  logic          q_not_empty;

  utt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .unit_valid (unit_valid),
    .unit_stall (unit_stall),
    .unit_data  (unit_data),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (push_job)
  );

  utt_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (push_job),
    .pop       (q_pop),
    .head      (head_job),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  utt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head_job),
    .not_empty (q_not_empty),
    .pop       (q_pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
  );

  `UTT_ASSERT_ALWAYS(a_no_overflow, !(q_push && q_full))
  `UTT_ASSERT_ALWAYS(a_no_underflow, !(q_pop && !q_not_empty))
  `UTT_ASSERT_IMPLY(a_err_no_byte,
                    res_valid && (res_data.error_code != utt_pkg::ERR_OK),
                    !res_data.byte_valid && res_data.last_of_run && res_data.end_of_string)
  `UTT_ASSERT_IMPLY(a_eos_ends_run, res_valid && res_data.end_of_string,
                    res_data.last_of_run)

endmodule
